// ===== rtl/next_fit_contiguous_page_allocator_top_defines.svh =====
// assertion macros shared by the allocator checker
`ifndef NEXT_FIT_CONTIGUOUS_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define NEXT_FIT_CONTIGUOUS_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// property checked outside reset
`define NFCA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that also looks at the reset itself
`define NFCA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/nfca_pkg.sv =====
// types and constants of the next-fit contiguous page allocator
`timescale 1ns / 1ps

package nfca_pkg;

   localparam int PAGES       = 1024;
   localparam int PAGE_IDX_W  = $clog2(PAGES);
   localparam int COUNT_W     = $clog2(PAGES) + 1;
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_W      = 22;
   localparam int REQ_DATA_W  = ((COUNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((ADDR_W + 7) / 8) * 8;

   typedef logic [PAGE_IDX_W-1:0] page_idx_type;
   typedef logic [COUNT_W-1:0]    count_type;

   localparam page_idx_type LAST_PAGE = page_idx_type'(PAGES - 1);
   localparam count_type    PAGE_COUNT = count_type'(PAGES);

   // access to the used map from the sequencer
   typedef struct packed {
      logic         rd_en;
      page_idx_type rd_addr;
      logic         wr_en;
      page_idx_type wr_addr;
   } map_req_type;

   // map status back to the sequencer
   typedef struct packed {
      logic ready;
      logic rd_data;
   } map_rsp_type;

endpackage

// ===== rtl/next_fit_contiguous_page_allocator_top.sv =====
// Next-fit contiguous page allocator, top level
//
// A request item on the req_ channel carries a page count. The block scans
// its used map from the next-fit pointer for that many consecutive free
// pages, never letting a run cross from the last page to page 0. One
// response item on the rsp_ channel follows every request: tuser says
// whether a run was found, tdata holds the byte address of its first page
// (0 when nothing was found). A count of 0 or above the page total fails
// at once without touching the map.
// The map is read one page a cycle (one memory read port), then a found
// run is marked one page a cycle (one write port). One request is worked
// on at a time; the next one is taken as soon as the previous response
// sits in the output register.
// Reset: the pointer returns to page 0 and a clearing pass writes the map
// (page 0 used, all others free); req_tready stays low until it ends. A
// stalled response holds its item and blocks completion of the following
// request until rsp_tready takes it.
`timescale 1ns / 1ps

module next_fit_contiguous_page_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // page_count [10:0], zero fill above
   input  logic [nfca_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // start_address [21:0], zero fill above
   output logic [nfca_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found [0]
   output logic [0:0]                      rsp_tuser
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_MARK = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;
   localparam int FULL_W = nfca_pkg::PAGE_IDX_W + nfca_pkg::PAGE_SHIFT;

   nfca_pkg::map_req_type  map_req;
   nfca_pkg::map_rsp_type  map_rsp;

   logic [1:0]             state_ff,      state_in;
   nfca_pkg::count_type    want_ff,       want_in;
   nfca_pkg::page_idx_type iss_ff,        iss_in;
   logic                   look_valid_ff, look_valid_in;
   nfca_pkg::page_idx_type look_pos_ff,   look_pos_in;
   nfca_pkg::count_type    run_ff,        run_in;
   nfca_pkg::page_idx_type first_ff,      first_in;
   nfca_pkg::count_type    checked_ff,    checked_in;
   nfca_pkg::page_idx_type ptr_ff,        ptr_in;
   nfca_pkg::page_idx_type mark_addr_ff,  mark_addr_in;
   nfca_pkg::count_type    mark_left_ff,  mark_left_in;
   logic                   found_ff,      found_in;
   logic                   rsp_valid_ff,  rsp_valid_in;
   logic                   rsp_found_ff,  rsp_found_in;
   logic [nfca_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   nfca_pkg::count_type    req_count;
   nfca_pkg::count_type    eff_run;
   nfca_pkg::count_type    run_plus;
   nfca_pkg::count_type    checked_plus;
   nfca_pkg::page_idx_type step_first;
   logic                   page_free;
   logic                   hit;
   logic                   exhausted;
   logic                   req_fire;
   logic [FULL_W-1:0]      full_addr;

   nfca_used_map u_used_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .map_rsp (map_rsp)
   );

   assign req_count  = req_tdata[nfca_pkg::COUNT_W-1:0];
   assign req_tready = (state_ff == ST_IDLE) && map_rsp.ready;
   assign req_fire   = req_tvalid && req_tready;

   // one scan step on the page whose mark has just come back
   always_comb begin
      eff_run      = (look_pos_ff == '0) ? '0 : run_ff;
      run_plus     = eff_run + 1'b1;
      step_first   = (eff_run == '0) ? look_pos_ff : first_ff;
      page_free    = ~map_rsp.rd_data;
      checked_plus = checked_ff + 1'b1;
      hit          = look_valid_ff && page_free && (run_plus == want_ff);
      exhausted    = look_valid_ff && !hit && (checked_plus == nfca_pkg::PAGE_COUNT);
   end

   assign full_addr = {first_ff, {nfca_pkg::PAGE_SHIFT{1'b0}}};

   // request sequencer
   always_comb begin
      state_in      = state_ff;
      want_in       = want_ff;
      iss_in        = iss_ff;
      look_valid_in = 1'b0;
      look_pos_in   = look_pos_ff;
      run_in        = run_ff;
      first_in      = first_ff;
      checked_in    = checked_ff;
      ptr_in        = ptr_ff;
      mark_addr_in  = mark_addr_ff;
      mark_left_in  = mark_left_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_addr_in   = rsp_addr_ff;
      map_req       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               want_in    = req_count;
               iss_in     = ptr_ff;
               run_in     = '0;
               checked_in = '0;
               found_in   = 1'b0;
               if (req_count == '0 || req_count > nfca_pkg::PAGE_COUNT) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue the next page while the previous one is judged
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = iss_ff;
            iss_in          = (iss_ff == nfca_pkg::LAST_PAGE) ? '0 : iss_ff + 1'b1;
            look_valid_in   = 1'b1;
            look_pos_in     = iss_ff;
            if (look_valid_ff) begin
               checked_in = checked_plus;
               first_in   = step_first;
               run_in     = page_free ? run_plus : '0;
               if (hit) begin
                  found_in      = 1'b1;
                  mark_addr_in  = step_first;
                  mark_left_in  = want_ff;
                  ptr_in        = (look_pos_ff == nfca_pkg::LAST_PAGE) ? '0
                                                                    : look_pos_ff + 1'b1;
                  look_valid_in = 1'b0;
                  state_in      = ST_MARK;
               end else if (exhausted) begin
                  look_valid_in = 1'b0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_MARK: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = mark_addr_ff;
            mark_addr_in    = mark_addr_ff + 1'b1;
            mark_left_in    = mark_left_ff - 1'b1;
            if (mark_left_ff == nfca_pkg::count_type'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_addr_in  = found_ff ? nfca_pkg::ADDR_W'(full_addr) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         look_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         look_valid_ff <= look_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      want_ff      <= want_in;
      iss_ff       <= iss_in;
      look_pos_ff  <= look_pos_in;
      run_ff       <= run_in;
      first_ff     <= first_in;
      checked_ff   <= checked_in;
      mark_addr_ff <= mark_addr_in;
      mark_left_ff <= mark_left_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(nfca_pkg::RSP_DATA_W - nfca_pkg::ADDR_W){1'b0}}, rsp_addr_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

// ===== rtl/nfca_used_map.sv =====
// one-bit-per-page used map with its clearing pass after reset
`timescale 1ns / 1ps

module nfca_used_map (
   input  logic                 clock,
   input  logic                 reset,
   input  nfca_pkg::map_req_type map_req,
   output nfca_pkg::map_rsp_type map_rsp
);

   logic                   mem [nfca_pkg::PAGES];
   logic                   clr_busy_ff;
   logic                   clr_busy_in;
   nfca_pkg::page_idx_type clr_addr_ff;
   nfca_pkg::page_idx_type clr_addr_in;
   logic                   rd_data_ff;

   // clearing sweep, page 0 comes out used
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == nfca_pkg::LAST_PAGE) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // single write port: sweep first, then marks
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= (clr_addr_ff == '0);
      end else if (map_req.wr_en) begin
         mem[map_req.wr_addr] <= 1'b1;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (map_req.rd_en) begin
         rd_data_ff <= mem[map_req.rd_addr];
      end
   end

   assign map_rsp.ready   = ~clr_busy_ff;
   assign map_rsp.rd_data = rd_data_ff;

endmodule

// ===== rtl/nfca_checker.sv =====
// port-level checks of the allocator and their binding
`timescale 1ns / 1ps
`include "next_fit_contiguous_page_allocator_top_defines.svh"

module nfca_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [nfca_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                      rsp_tuser
);

   // map clearing keeps requests out right after reset
   `NFCA_ASSERT_RST(a_clear_blocks, reset |=> !req_tready, "request taken during map clearing")

   // one request in flight at a time
   `NFCA_ASSERT(a_one_in_flight, req_tvalid && req_tready |=> !req_tready, "second request taken while busy")

   // a failed item carries address zero
   `NFCA_ASSERT(a_miss_zero, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0, "failed item with nonzero address")

   // a found run is page aligned and never page 0, which stays reserved
   `NFCA_ASSERT(a_hit_addr, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[nfca_pkg::PAGE_SHIFT-1:0] == '0 && rsp_tdata != '0, "bad address on found item")

   // a stalled item holds
   `NFCA_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled item changed")

endmodule

bind next_fit_contiguous_page_allocator_top nfca_checker u_nfca_checker (.*);
